[design/jtl_pkg.sv]
// Shared types and constants for the JSON token lexer.
// Used by every module of the lexer; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package jtl_pkg;

  // Depth of the queue between the front and back halves.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    KIND_EOF      = 4'd0,
    KIND_LBRACE   = 4'd1,
    KIND_RBRACE   = 4'd2,
    KIND_LBRACKET = 4'd3,
    KIND_RBRACKET = 4'd4,
    KIND_COLON    = 4'd5,
    KIND_COMMA    = 4'd6,
    KIND_STRING   = 4'd7,
    KIND_NUMBER   = 4'd8,
    KIND_BOOLEAN  = 4'd9,
    KIND_NULL     = 4'd10,
    KIND_ILLEGAL  = 4'd11
  } jtl_kind_t;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_STR  = 3'd1,
    MODE_NUM  = 3'd2,
    MODE_BOOL = 3'd3,
    MODE_NULL = 3'd4
  } jtl_mode_t;

  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_VT       = 8'h0B;
  localparam logic [7:0] CH_FF       = 8'h0C;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_LC_F     = 8'h66;
  localparam logic [7:0] CH_LC_N     = 8'h6E;
  localparam logic [7:0] CH_LC_T     = 8'h74;
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;

  // "null", indexed by the number of bytes already matched
  localparam logic [7:0] NULL_WORD [4] = '{8'h6E, 8'h75, 8'h6C, 8'h6C};

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } jtl_in_t;

  typedef struct packed {
    jtl_kind_t  kind;
    logic [7:0] text_byte;
    logic       has_byte;
    logic       token_start;
    logic       token_end;
    logic       last_of_run;
  } jtl_out_t;

  // All results of one input byte: one or two items.
  typedef struct packed {
    logic     two;
    jtl_out_t first;
    jtl_out_t second;
  } jtl_entry_t;

endpackage

`default_nettype wire

[design/jtl_front.sv]
// Front half of the lexer: takes one byte per cycle while the queue has room, runs
// the mode machine and bundles the byte's results into one queue entry. Uses jtl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jtl_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  jtl_pkg::jtl_in_t     in_data,
  input  wire                  q_ready,
  output logic                 q_push,
  output jtl_pkg::jtl_entry_t  q_data
);
  import jtl_pkg::*;

  jtl_mode_t  mode_r, mode_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  logic [7:0] b;
  logic       eoi;
  logic       is_space;
  logic       is_delim;
  logic       null_match;
  logic       accept;

  // outcome of lexing b from idle
  logic       idle_v;
  jtl_out_t   idle_item;
  jtl_mode_t  idle_mode;
  logic [1:0] idle_cnt;

  jtl_out_t   r0, r1;
  logic [1:0] n;

  function automatic jtl_out_t mk_item(jtl_kind_t k, logic [7:0] by, logic has,
                                       logic s, logic e);
    jtl_out_t it;
    it.kind        = k;
    it.text_byte   = has ? by : 8'h00;
    it.has_byte    = has;
    it.token_start = s;
    it.token_end   = e;
    it.last_of_run = 1'b0;
    return it;
  endfunction

  assign b        = in_data.in_byte;
  assign eoi      = in_data.end_of_input || (b == CH_NUL);
  assign is_space = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) ||
                    (b == CH_VT) || (b == CH_FF) || (b == CH_CR);
  assign is_delim = is_space || (b == CH_COMMA) || (b == CH_RBRACE) ||
                    (b == CH_RBRACKET);
  assign null_match = (cnt_r != 2'd0) && (b == NULL_WORD[cnt_r]);

  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    idle_v    = 1'b1;
    idle_mode = MODE_IDLE;
    idle_cnt  = 2'd0;
    idle_item = mk_item(KIND_ILLEGAL, b, 1'b1, 1'b1, 1'b1);
    priority if (is_space) begin
      idle_v = 1'b0;
    end else if (b == CH_LBRACE) begin
      idle_item = mk_item(KIND_LBRACE, b, 1'b1, 1'b1, 1'b1);
    end else if (b == CH_RBRACE) begin
      idle_item = mk_item(KIND_RBRACE, b, 1'b1, 1'b1, 1'b1);
    end else if (b == CH_LBRACKET) begin
      idle_item = mk_item(KIND_LBRACKET, b, 1'b1, 1'b1, 1'b1);
    end else if (b == CH_RBRACKET) begin
      idle_item = mk_item(KIND_RBRACKET, b, 1'b1, 1'b1, 1'b1);
    end else if (b == CH_COLON) begin
      idle_item = mk_item(KIND_COLON, b, 1'b1, 1'b1, 1'b1);
    end else if (b == CH_COMMA) begin
      idle_item = mk_item(KIND_COMMA, b, 1'b1, 1'b1, 1'b1);
    end else if (b == CH_QUOTE) begin
      idle_mode = MODE_STR;
      idle_item = mk_item(KIND_STRING, b, 1'b0, 1'b1, 1'b0);
    end else if ((b >= CH_ZERO) && (b <= CH_NINE)) begin
      idle_mode = MODE_NUM;
      idle_item = mk_item(KIND_NUMBER, b, 1'b1, 1'b1, 1'b0);
    end else if ((b == CH_LC_T) || (b == CH_LC_F)) begin
      idle_mode = MODE_BOOL;
      idle_item = mk_item(KIND_BOOLEAN, b, 1'b1, 1'b1, 1'b0);
    end else if (b == CH_LC_N) begin
      idle_v    = 1'b0;
      idle_mode = MODE_NULL;
      idle_cnt  = 2'd1;
    end else begin
      idle_v = 1'b1;
    end
  end

  // next state
  always_comb begin
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    if (eoi) begin
      mode_nxt = MODE_IDLE;
      cnt_nxt  = 2'd0;
    end else begin
      unique case (mode_r)
        MODE_STR: begin
          if (b == CH_QUOTE) mode_nxt = MODE_IDLE;
        end
        MODE_NUM, MODE_BOOL: begin
          if (is_delim) begin
            mode_nxt = idle_mode;
            cnt_nxt  = idle_cnt;
          end
        end
        MODE_NULL: begin
          if (null_match && (cnt_r == 2'd3)) begin
            mode_nxt = MODE_IDLE;
            cnt_nxt  = 2'd0;
          end else if (null_match) begin
            cnt_nxt = cnt_r + 2'd1;
          end else begin
            mode_nxt = idle_mode;
            cnt_nxt  = idle_cnt;
          end
        end
        default: begin
          mode_nxt = idle_mode;
          cnt_nxt  = idle_cnt;
        end
      endcase
    end
  end

  // results of the current byte
  always_comb begin
    r0 = idle_item;
    r1 = idle_item;
    n  = {1'b0, idle_v};
    if (eoi) begin
      r1 = mk_item(KIND_EOF, b, 1'b0, 1'b1, 1'b1);
      n  = 2'd2;
      unique case (mode_r)
        MODE_STR:  r0 = mk_item(KIND_STRING, b, 1'b0, 1'b0, 1'b1);
        MODE_NUM:  r0 = mk_item(KIND_NUMBER, b, 1'b0, 1'b0, 1'b1);
        MODE_BOOL: r0 = mk_item(KIND_BOOLEAN, b, 1'b0, 1'b0, 1'b1);
        MODE_NULL: r0 = mk_item(KIND_ILLEGAL, b, 1'b0, 1'b1, 1'b1);
        default: begin
          r0 = r1;
          n  = 2'd1;
        end
      endcase
    end else begin
      unique case (mode_r)
        MODE_STR: begin
          n = 2'd1;
          if (b == CH_QUOTE) r0 = mk_item(KIND_STRING, b, 1'b0, 1'b0, 1'b1);
          else               r0 = mk_item(KIND_STRING, b, 1'b1, 1'b0, 1'b0);
        end
        MODE_NUM, MODE_BOOL: begin
          if (is_delim) begin
            r0 = mk_item((mode_r == MODE_NUM) ? KIND_NUMBER : KIND_BOOLEAN,
                         b, 1'b0, 1'b0, 1'b1);
            n  = idle_v ? 2'd2 : 2'd1;
          end else begin
            r0 = mk_item((mode_r == MODE_NUM) ? KIND_NUMBER : KIND_BOOLEAN,
                         b, 1'b1, 1'b0, 1'b0);
            n  = 2'd1;
          end
        end
        MODE_NULL: begin
          if (null_match && (cnt_r == 2'd3)) begin
            r0 = mk_item(KIND_NULL, b, 1'b0, 1'b1, 1'b1);
            n  = 2'd1;
          end else if (null_match) begin
            n = 2'd0;
          end else begin
            r0 = mk_item(KIND_ILLEGAL, b, 1'b0, 1'b1, 1'b1);
            n  = idle_v ? 2'd2 : 2'd1;
          end
        end
        default: begin
          r0 = idle_item;
          n  = {1'b0, idle_v};
        end
      endcase
    end
    r0.last_of_run = (n == 2'd1);
    r1.last_of_run = 1'b1;
  end

  assign q_push        = accept && (n != 2'd0);
  assign q_data.two    = (n == 2'd2);
  assign q_data.first  = r0;
  assign q_data.second = r1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      cnt_r  <= 2'd0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // the match counter only runs while matching null
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != MODE_NULL) |-> (cnt_r == 2'd0))
    else $error("null match count set outside null mode");

  a_null_partial: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (mode_r == MODE_NULL) && !eoi && null_match && (cnt_r != 2'd3))
      |=> (mode_r == MODE_NULL) && (cnt_r == $past(cnt_r) + 2'd1))
    else $error("partial null match did not advance");

  a_eoi_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && eoi) |=> (mode_r == MODE_IDLE))
    else $error("end of input left lexer busy");

endmodule

`default_nettype wire

[design/jtl_queue.sv]
// Short queue of result entries between the front and back halves.
// Uses jtl_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none

module jtl_queue (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  jtl_pkg::jtl_entry_t  push_data,
  output logic                 push_ready,
  input  wire                  pop,
  output logic                 pop_valid,
  output jtl_pkg::jtl_entry_t  pop_data
);
  import jtl_pkg::*;

  jtl_entry_t            mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QUEUE_CW-1:0]   count_r, count_nxt;

  assign push_ready = (count_r != QUEUE_CW'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop)      count_nxt = count_r + 1'b1;
    else if (!push && pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> push_ready)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> pop_valid)
    else $error("pop from empty queue");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QUEUE_CW'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

`default_nettype wire

[design/jtl_back.sv]
// Back half of the lexer: splits queue entries into single result items
// and holds them in the output register. Uses jtl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jtl_back (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  q_valid,
  input  jtl_pkg::jtl_entry_t  q_data,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire                  out_ready,
  output jtl_pkg::jtl_out_t    out_data
);
  import jtl_pkg::*;

  logic     out_valid_r;
  jtl_out_t out_data_r;
  logic     sel_r;      // head entry's first item already loaded
  logic     load;

  assign load      = q_valid && (!out_valid_r || out_ready);
  assign q_pop     = load && (!q_data.two || sel_r);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (load) out_data_r <= sel_r ? q_data.second : q_data.first;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sel_r       <= 1'b0;
    end else begin
      if (load)           out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (load) sel_r <= q_data.two && !sel_r;
    end
  end

  a_sel_pair: assert property (@(posedge clk) disable iff (!rst_n)
    sel_r |-> (q_valid && q_data.two))
    else $error("second item pending without a paired entry");

  a_second_last: assert property (@(posedge clk) disable iff (!rst_n)
    (load && sel_r) |=> out_data_r.last_of_run)
    else $error("second item of a pair is not last of run");

  a_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r && $stable(out_data_r))
    else $error("result changed while stalled");

endmodule

`default_nettype wire

[design/json_token_lexer.sv]
// Top level of the JSON token lexer: front half, entry queue, back half.
// Uses jtl_pkg, jtl_front, jtl_queue and jtl_back.
`timescale 1ns / 1ps
`default_nettype none

// Takes JSON text one byte per transfer and returns token items on the out
// channel. A byte is taken every cycle while the four-entry queue between the
// front and back halves has room; each byte produces zero, one or two result
// items, and the output register sends one item per cycle while out_ready is
// high, so the sustained rate is one byte per cycle when each byte yields at
// most one item, else as fast as the output sends items. Results pass the
// queue, then the output register. A zero byte acts as end of input.
module json_token_lexer (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  jtl_pkg::jtl_in_t   in_data,
  output logic               out_valid,
  input  wire                out_ready,
  output jtl_pkg::jtl_out_t  out_data
);
  import jtl_pkg::*;

  logic       q_push, q_ready, q_valid, q_pop;
  jtl_entry_t q_wdata, q_rdata;

  jtl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  jtl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_wdata),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_rdata)
  );

  jtl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
